@@ rtl/core/dqpi_pkg.sv @@
// Package for the dq current PI controller: payload structs, register indexes,
// micro-op encodings and the sequencer program that drives the shared unit.
// No dependencies.
`default_nettype none

package dqpi_pkg;

    typedef struct packed {
        logic signed [31:0] ref_current_d;
        logic signed [31:0] ref_current_q;
        logic signed [31:0] meas_current_d;
        logic signed [31:0] meas_current_q;
        logic signed [31:0] meas_voltage_d;
        logic signed [31:0] meas_voltage_q;
        logic signed [31:0] grid_omega;
        logic [30:0]        dc_link_voltage;
        logic [1:0]         integ_command;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] modulation_d;
        logic signed [31:0] modulation_q;
        logic               dc_zero_flag;
    } result_t;

    typedef enum logic [2:0] {
        CFG_PROP_GAIN     = 3'd0,
        CFG_INTEG_GAIN    = 3'd1,
        CFG_INDUCTANCE    = 3'd2,
        CFG_SAMPLE_PERIOD = 3'd3,
        CFG_RESONANT_MODE = 3'd4,
        CFG_NOTCH_GAIN    = 3'd5,
        CFG_NOTCH_A       = 3'd6,
        CFG_NOTCH_B       = 3'd7
    } cfg_idx_t;

    localparam logic [1:0] CMD_CLEAR     = 2'd0;
    localparam logic [1:0] CMD_INTEGRATE = 2'd1;
    localparam logic [1:0] MODE_CURRENT  = 2'd1;
    localparam logic [1:0] MODE_VOLTAGE  = 2'd2;

    localparam logic [31:0] NOTCH_GAIN_RST = 32'd195555230;
    localparam logic [31:0] NOTCH_A_RST    = 32'd536605998;
    localparam logic [31:0] NOTCH_B_RST    = 32'd134177194;
    localparam logic signed [63:0] CWT2_Q28 = 64'sd536605999;
    localparam logic signed [63:0] C707_Q28 = 64'sd189783867;

    typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB, OP_DIV} op_t;
    typedef enum logic [1:0] {C_ALL, C_RES, C_INT, C_NONE} cond_t;
    typedef enum logic [1:0] {SH16, SH28, SH32} shift_t;

    typedef enum logic [5:0] {
        SRC_T0, SRC_T1, SRC_SC, SRC_ED, SRC_EQ, SRC_WL,
        SRC_RD, SRC_RQ, SRC_IDM, SRC_IQM, SRC_VD, SRC_VQ, SRC_W,
        SRC_KP, SRC_KI, SRC_L, SRC_TS, SRC_K, SRC_A, SRC_B,
        SRC_CWT2, SRC_C707, SRC_ONE,
        SRC_RESX_D, SRC_RESX_Q, SRC_RC_D, SRC_RC_Q, SRC_RV_D, SRC_RV_Q,
        SRC_INTD, SRC_INTQ,
        SRC_RHD0, SRC_RHD1, SRC_RHQ0, SRC_RHQ1,
        SRC_NID0, SRC_NID1, SRC_NIQ0, SRC_NIQ1,
        SRC_NOD0, SRC_NOD1, SRC_NOQ0, SRC_NOQ1
    } src_t;
    localparam int SRC_COUNT = 43;

    typedef enum logic [3:0] {
        DST_T0, DST_T1, DST_SC, DST_ED, DST_EQ, DST_WL, DST_INTD, DST_INTQ,
        DST_RESD, DST_RESQ, DST_NOTCHD, DST_NOTCHQ, DST_OUTD, DST_OUTQ
    } dst_t;

    typedef struct packed {
        op_t    op;
        cond_t  cond;
        src_t   srca;
        src_t   srcb;
        shift_t sh;
        logic   neg;
        dst_t   dst;
    } uop_t;

    localparam logic [5:0] PROG_LEN = 6'd55;

    function automatic uop_t prog_rom(input logic [5:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = '{OP_MUL, C_RES, SRC_RESX_D, SRC_TS, SH32, 1'b1, DST_T0};
            6'd1:  u = '{OP_MUL, C_RES, SRC_RHD0, SRC_CWT2, SH28, 1'b0, DST_T1};
            6'd2:  u = '{OP_ADD, C_RES, SRC_T0, SRC_T1, SH16, 1'b0, DST_T0};
            6'd3:  u = '{OP_SUB, C_RES, SRC_T0, SRC_RHD1, SH16, 1'b0, DST_RESD};
            6'd4:  u = '{OP_MUL, C_RES, SRC_RESX_Q, SRC_TS, SH32, 1'b1, DST_T0};
            6'd5:  u = '{OP_MUL, C_RES, SRC_RHQ0, SRC_CWT2, SH28, 1'b0, DST_T1};
            6'd6:  u = '{OP_ADD, C_RES, SRC_T0, SRC_T1, SH16, 1'b0, DST_T0};
            6'd7:  u = '{OP_SUB, C_RES, SRC_T0, SRC_RHQ1, SH16, 1'b0, DST_RESQ};
            6'd8:  u = '{OP_SUB, C_ALL, SRC_RD, SRC_IDM, SH16, 1'b0, DST_T0};
            6'd9:  u = '{OP_ADD, C_ALL, SRC_T0, SRC_RV_D, SH16, 1'b0, DST_ED};
            6'd10: u = '{OP_SUB, C_ALL, SRC_RQ, SRC_IQM, SH16, 1'b0, DST_T0};
            6'd11: u = '{OP_ADD, C_ALL, SRC_T0, SRC_RV_Q, SH16, 1'b0, DST_EQ};
            6'd12: u = '{OP_MUL, C_ALL, SRC_W, SRC_L, SH16, 1'b0, DST_WL};
            6'd13: u = '{OP_MUL, C_ALL, SRC_KP, SRC_ED, SH16, 1'b0, DST_T0};
            6'd14: u = '{OP_MUL, C_ALL, SRC_KI, SRC_INTD, SH16, 1'b0, DST_T1};
            6'd15: u = '{OP_ADD, C_ALL, SRC_T0, SRC_T1, SH16, 1'b0, DST_T0};
            6'd16: u = '{OP_MUL, C_ALL, SRC_WL, SRC_IQM, SH32, 1'b0, DST_T1};
            6'd17: u = '{OP_SUB, C_ALL, SRC_T0, SRC_T1, SH16, 1'b0, DST_T0};
            6'd18: u = '{OP_ADD, C_ALL, SRC_T0, SRC_VD, SH16, 1'b0, DST_T0};
            6'd19: u = '{OP_ADD, C_ALL, SRC_T0, SRC_RC_D, SH16, 1'b0, DST_T0};
            6'd20: u = '{OP_DIV, C_ALL, SRC_T0, SRC_ONE, SH16, 1'b0, DST_SC};
            6'd21: u = '{OP_MUL, C_ALL, SRC_K, SRC_NID0, SH28, 1'b0, DST_T0};
            6'd22: u = '{OP_MUL, C_ALL, SRC_C707, SRC_NOD0, SH28, 1'b0, DST_T1};
            6'd23: u = '{OP_SUB, C_ALL, SRC_T0, SRC_T1, SH16, 1'b0, DST_T0};
            6'd24: u = '{OP_MUL, C_ALL, SRC_A, SRC_T0, SH28, 1'b0, DST_T1};
            6'd25: u = '{OP_MUL, C_ALL, SRC_K, SRC_SC, SH28, 1'b0, DST_T0};
            6'd26: u = '{OP_SUB, C_ALL, SRC_T0, SRC_T1, SH16, 1'b0, DST_T0};
            6'd27: u = '{OP_MUL, C_ALL, SRC_K, SRC_NID1, SH28, 1'b0, DST_T1};
            6'd28: u = '{OP_ADD, C_ALL, SRC_T0, SRC_T1, SH16, 1'b0, DST_T0};
            6'd29: u = '{OP_MUL, C_ALL, SRC_B, SRC_NOD1, SH28, 1'b0, DST_T1};
            6'd30: u = '{OP_SUB, C_ALL, SRC_T0, SRC_T1, SH16, 1'b0, DST_NOTCHD};
            6'd31: u = '{OP_MUL, C_ALL, SRC_NOD0, SRC_ONE, SH16, 1'b0, DST_OUTD};
            6'd32: u = '{OP_MUL, C_INT, SRC_ED, SRC_TS, SH32, 1'b0, DST_T0};
            6'd33: u = '{OP_ADD, C_INT, SRC_INTD, SRC_T0, SH16, 1'b0, DST_INTD};
            6'd34: u = '{OP_MUL, C_ALL, SRC_KP, SRC_EQ, SH16, 1'b0, DST_T0};
            6'd35: u = '{OP_MUL, C_ALL, SRC_KI, SRC_INTQ, SH16, 1'b0, DST_T1};
            6'd36: u = '{OP_ADD, C_ALL, SRC_T0, SRC_T1, SH16, 1'b0, DST_T0};
            6'd37: u = '{OP_MUL, C_ALL, SRC_WL, SRC_IDM, SH32, 1'b0, DST_T1};
            6'd38: u = '{OP_ADD, C_ALL, SRC_T0, SRC_T1, SH16, 1'b0, DST_T0};
            6'd39: u = '{OP_ADD, C_ALL, SRC_T0, SRC_VQ, SH16, 1'b0, DST_T0};
            6'd40: u = '{OP_ADD, C_ALL, SRC_T0, SRC_RC_Q, SH16, 1'b0, DST_T0};
            6'd41: u = '{OP_DIV, C_ALL, SRC_T0, SRC_ONE, SH16, 1'b0, DST_SC};
            6'd42: u = '{OP_MUL, C_ALL, SRC_K, SRC_NIQ0, SH28, 1'b0, DST_T0};
            6'd43: u = '{OP_MUL, C_ALL, SRC_C707, SRC_NOQ0, SH28, 1'b0, DST_T1};
            6'd44: u = '{OP_SUB, C_ALL, SRC_T0, SRC_T1, SH16, 1'b0, DST_T0};
            6'd45: u = '{OP_MUL, C_ALL, SRC_A, SRC_T0, SH28, 1'b0, DST_T1};
            6'd46: u = '{OP_MUL, C_ALL, SRC_K, SRC_SC, SH28, 1'b0, DST_T0};
            6'd47: u = '{OP_SUB, C_ALL, SRC_T0, SRC_T1, SH16, 1'b0, DST_T0};
            6'd48: u = '{OP_MUL, C_ALL, SRC_K, SRC_NIQ1, SH28, 1'b0, DST_T1};
            6'd49: u = '{OP_ADD, C_ALL, SRC_T0, SRC_T1, SH16, 1'b0, DST_T0};
            6'd50: u = '{OP_MUL, C_ALL, SRC_B, SRC_NOQ1, SH28, 1'b0, DST_T1};
            6'd51: u = '{OP_SUB, C_ALL, SRC_T0, SRC_T1, SH16, 1'b0, DST_NOTCHQ};
            6'd52: u = '{OP_MUL, C_ALL, SRC_NOQ0, SRC_ONE, SH16, 1'b0, DST_OUTQ};
            6'd53: u = '{OP_MUL, C_INT, SRC_EQ, SRC_TS, SH32, 1'b0, DST_T0};
            6'd54: u = '{OP_ADD, C_INT, SRC_INTQ, SRC_T0, SH16, 1'b0, DST_INTQ};
            default: u = '{OP_ADD, C_NONE, SRC_T0, SRC_T0, SH16, 1'b0, DST_T0};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/dq_current_pi_controller.sv @@
// Runs each sample as a program of 55 micro-ops on one shared unit: a 32x32 multiplier
// that builds each product from four partial products, and a restoring divider per axis
// that is skipped when Vdc is zero or the quotient would overflow.
// The input stalls until the result transfers, so no new sample is taken before then.
// Reset clears the sequencer, the integrators and all filter history, and loads
// the register defaults.
// Depends on dqpi_pkg.
`default_nettype none

module dq_current_pi_controller
    import dqpi_pkg::*;
#(
    parameter int SIGNAL_WIDTH = 32,
    parameter int STATE_WIDTH  = 48
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    sample_valid,
    output logic         sample_stall,
    input  wire sample_t sample,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result,
    input  wire logic    cfg_write_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam logic signed [64:0] ST_HI = (65'sd1 <<< (STATE_WIDTH - 1)) - 65'sd1;
    localparam logic signed [64:0] ST_LO = -ST_HI - 65'sd1;
    localparam logic signed [64:0] SG_HI = (65'sd1 <<< (SIGNAL_WIDTH - 1)) - 65'sd1;
    localparam logic signed [64:0] SG_LO = -SG_HI - 65'sd1;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_FETCH = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_MFIN  = 8'b0000_1000,
        ST_ALU   = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_DFIN  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    function automatic logic signed [63:0] sat_state(input logic signed [64:0] x);
        logic signed [64:0] y;
        y = (x > ST_HI) ? ST_HI : ((x < ST_LO) ? ST_LO : x);
        return y[63:0];
    endfunction

    function automatic logic signed [31:0] sat_signal(input logic signed [63:0] x);
        logic signed [64:0] xe;
        logic signed [64:0] y;
        xe = {x[63], x};
        y  = (xe > SG_HI) ? SG_HI : ((xe < SG_LO) ? SG_LO : xe);
        return y[31:0];
    endfunction

    function automatic logic [63:0] magn(input logic signed [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    state_t state_reg;
    logic [5:0] pc_reg;
    logic [5:0] cnt_reg;

    logic [31:0] prop_gain_reg, integ_gain_reg, inductance_reg, sample_period_reg;
    logic [1:0]  resonant_mode_reg;
    logic [31:0] notch_gain_reg, notch_a_reg, notch_b_reg;

    logic signed [63:0] intd_reg, intq_reg;
    logic signed [63:0] rhd0_reg, rhd1_reg, rhq0_reg, rhq1_reg;
    logic signed [63:0] nid0_reg, nid1_reg, niq0_reg, niq1_reg;
    logic signed [63:0] nod0_reg, nod1_reg, noq0_reg, noq1_reg;

    logic signed [63:0] rd_reg, rq_reg, idm_reg, iqm_reg, vd_reg, vq_reg, w_reg;
    logic [30:0] vdc_reg;
    logic [1:0]  cmd_reg;
    logic signed [63:0] t0_reg, t1_reg, sc_reg, ed_reg, eq_reg, wl_reg;
    logic signed [63:0] outd_reg, outq_reg;

    uop_t        uop_reg;
    logic [63:0] ma_reg, mb_reg;
    logic signed [63:0] va_reg, vb_reg;
    logic        sign_reg;
    logic [128:0] acc_reg;
    logic [30:0] rem_reg;
    logic [62:0] dq_reg;
    logic        dzero_reg, dovf_reg;

    logic signed [63:0] src_vec [SRC_COUNT];
    uop_t        uop;
    logic        res_mode, cond_ok;
    logic signed [63:0] fa, fb;
    logic [63:0] fma, fmb;
    logic        wr_en;
    logic signed [63:0] wr_val;
    logic [31:0] pp_a, pp_b;
    logic [63:0] pp;
    logic [128:0] pp_shift;
    logic [128:0] acc_sh;
    logic [63:0] mres;
    logic signed [64:0] alu_sum;
    logic [31:0] trial;
    logic        trial_ge;
    logic [63:0] dmag;
    logic signed [64:0] dval;
    logic [128:0] round_c;
    logic        sample_xfer;

    assign sample_stall = (state_reg != ST_IDLE);
    assign sample_xfer  = sample_valid && !sample_stall;
    assign result_valid = (state_reg == ST_DONE);
    assign result.modulation_d = sat_signal(outd_reg);
    assign result.modulation_q = sat_signal(outq_reg);
    assign result.dc_zero_flag = (vdc_reg == 31'd0);

    assign res_mode = (resonant_mode_reg == MODE_CURRENT) ||
                      (resonant_mode_reg == MODE_VOLTAGE);

    assign src_vec[SRC_T0]     = t0_reg;
    assign src_vec[SRC_T1]     = t1_reg;
    assign src_vec[SRC_SC]     = sc_reg;
    assign src_vec[SRC_ED]     = ed_reg;
    assign src_vec[SRC_EQ]     = eq_reg;
    assign src_vec[SRC_WL]     = wl_reg;
    assign src_vec[SRC_RD]     = rd_reg;
    assign src_vec[SRC_RQ]     = rq_reg;
    assign src_vec[SRC_IDM]    = idm_reg;
    assign src_vec[SRC_IQM]    = iqm_reg;
    assign src_vec[SRC_VD]     = vd_reg;
    assign src_vec[SRC_VQ]     = vq_reg;
    assign src_vec[SRC_W]      = w_reg;
    assign src_vec[SRC_KP]     = {32'd0, prop_gain_reg};
    assign src_vec[SRC_KI]     = {32'd0, integ_gain_reg};
    assign src_vec[SRC_L]      = {32'd0, inductance_reg};
    assign src_vec[SRC_TS]     = {32'd0, sample_period_reg};
    assign src_vec[SRC_K]      = {{32{notch_gain_reg[31]}}, notch_gain_reg};
    assign src_vec[SRC_A]      = {{32{notch_a_reg[31]}}, notch_a_reg};
    assign src_vec[SRC_B]      = {{32{notch_b_reg[31]}}, notch_b_reg};
    assign src_vec[SRC_CWT2]   = CWT2_Q28;
    assign src_vec[SRC_C707]   = C707_Q28;
    assign src_vec[SRC_ONE]    = 64'sd1;
    assign src_vec[SRC_RESX_D] = (resonant_mode_reg == MODE_CURRENT) ? idm_reg : vd_reg;
    assign src_vec[SRC_RESX_Q] = (resonant_mode_reg == MODE_CURRENT) ? iqm_reg : vq_reg;
    assign src_vec[SRC_RC_D]   = (resonant_mode_reg == MODE_CURRENT) ? rhd0_reg : 64'sd0;
    assign src_vec[SRC_RC_Q]   = (resonant_mode_reg == MODE_CURRENT) ? rhq0_reg : 64'sd0;
    assign src_vec[SRC_RV_D]   = (resonant_mode_reg == MODE_VOLTAGE) ? rhd0_reg : 64'sd0;
    assign src_vec[SRC_RV_Q]   = (resonant_mode_reg == MODE_VOLTAGE) ? rhq0_reg : 64'sd0;
    assign src_vec[SRC_INTD]   = intd_reg;
    assign src_vec[SRC_INTQ]   = intq_reg;
    assign src_vec[SRC_RHD0]   = rhd0_reg;
    assign src_vec[SRC_RHD1]   = rhd1_reg;
    assign src_vec[SRC_RHQ0]   = rhq0_reg;
    assign src_vec[SRC_RHQ1]   = rhq1_reg;
    assign src_vec[SRC_NID0]   = nid0_reg;
    assign src_vec[SRC_NID1]   = nid1_reg;
    assign src_vec[SRC_NIQ0]   = niq0_reg;
    assign src_vec[SRC_NIQ1]   = niq1_reg;
    assign src_vec[SRC_NOD0]   = nod0_reg;
    assign src_vec[SRC_NOD1]   = nod1_reg;
    assign src_vec[SRC_NOQ0]   = noq0_reg;
    assign src_vec[SRC_NOQ1]   = noq1_reg;

    always_comb
    begin
        uop = prog_rom(pc_reg);
        case (uop.cond)
            C_ALL:   cond_ok = 1'b1;
            C_RES:   cond_ok = res_mode;
            C_INT:   cond_ok = (cmd_reg == CMD_INTEGRATE);
            default: cond_ok = 1'b0;
        endcase
        fa  = src_vec[uop.srca];
        fb  = src_vec[uop.srcb];
        fma = magn(fa);
        fmb = magn(fb);
        case (uop.sh)
            SH16:    round_c = 129'd1 << 15;
            SH28:    round_c = 129'd1 << 27;
            default: round_c = 129'd1 << 31;
        endcase
    end

    always_comb
    begin
        pp_a = cnt_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        pp_b = cnt_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp   = pp_a * pp_b;
        case (cnt_reg[1:0])
            2'd0:    pp_shift = {65'd0, pp};
            2'd3:    pp_shift = {1'b0, pp, 64'd0};
            default: pp_shift = {33'd0, pp, 32'd0};
        endcase
        case (uop_reg.sh)
            SH16:    acc_sh = acc_reg >> 16;
            SH28:    acc_sh = acc_reg >> 28;
            default: acc_sh = acc_reg >> 32;
        endcase
        mres = (|acc_sh[128:63]) ? INT64_MAX : acc_sh[63:0];

        alu_sum = (uop_reg.op == OP_SUB) ? ({va_reg[63], va_reg} - {vb_reg[63], vb_reg})
                                         : ({va_reg[63], va_reg} + {vb_reg[63], vb_reg});

        trial    = {rem_reg, dq_reg[62]};
        trial_ge = (trial >= {1'b0, vdc_reg});

        dmag = dovf_reg ? INT64_MAX : {1'b0, dq_reg};
        dval = sign_reg ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});

        wr_en  = 1'b0;
        wr_val = 64'sd0;
        case (state_reg)
            ST_ALU:
            begin
                wr_en  = 1'b1;
                wr_val = sat_state(alu_sum);
            end
            ST_MFIN:
            begin
                wr_en  = 1'b1;
                wr_val = sat_state(sign_reg ? -$signed({1'b0, mres}) : $signed({1'b0, mres}));
            end
            ST_DFIN:
            begin
                wr_en = 1'b1;
                if (dzero_reg)
                begin
                    if (ma_reg == 64'd0)
                        wr_val = 64'sd0;
                    else
                        wr_val = sign_reg ? ST_LO[63:0] : ST_HI[63:0];
                end
                else
                begin
                    wr_val = sat_state(dval);
                end
            end
            default:
            begin
                wr_en  = 1'b0;
                wr_val = 64'sd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            pc_reg            <= 6'd0;
            cnt_reg           <= 6'd0;
            prop_gain_reg     <= 32'd0;
            integ_gain_reg    <= 32'd0;
            inductance_reg    <= 32'd0;
            sample_period_reg <= 32'd0;
            resonant_mode_reg <= 2'd0;
            notch_gain_reg    <= NOTCH_GAIN_RST;
            notch_a_reg       <= NOTCH_A_RST;
            notch_b_reg       <= NOTCH_B_RST;
            intd_reg <= 64'sd0;
            intq_reg <= 64'sd0;
            rhd0_reg <= 64'sd0;
            rhd1_reg <= 64'sd0;
            rhq0_reg <= 64'sd0;
            rhq1_reg <= 64'sd0;
            nid0_reg <= 64'sd0;
            nid1_reg <= 64'sd0;
            niq0_reg <= 64'sd0;
            niq1_reg <= 64'sd0;
            nod0_reg <= 64'sd0;
            nod1_reg <= 64'sd0;
            noq0_reg <= 64'sd0;
            noq1_reg <= 64'sd0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                    CFG_INTEG_GAIN:    integ_gain_reg    <= cfg_data;
                    CFG_INDUCTANCE:    inductance_reg    <= cfg_data;
                    CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data;
                    CFG_RESONANT_MODE: resonant_mode_reg <= cfg_data[1:0];
                    CFG_NOTCH_GAIN:    notch_gain_reg    <= cfg_data;
                    CFG_NOTCH_A:       notch_a_reg       <= cfg_data;
                    CFG_NOTCH_B:       notch_b_reg       <= cfg_data;
                    default:           ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample_xfer)
                    begin
                        pc_reg    <= 6'd0;
                        state_reg <= ST_FETCH;
                        if (sample.integ_command == CMD_CLEAR)
                        begin
                            intd_reg <= 64'sd0;
                            intq_reg <= 64'sd0;
                        end
                    end
                end
                ST_FETCH:
                begin
                    cnt_reg <= 6'd0;
                    if (pc_reg == PROG_LEN)
                        state_reg <= ST_DONE;
                    else if (!cond_ok)
                        pc_reg <= pc_reg + 6'd1;
                    else
                    begin
                        case (uop.op)
                            OP_MUL:  state_reg <= ST_MUL;
                            OP_DIV:
                            begin
                                if ((vdc_reg == 31'd0) || ({13'd0, fma[63:46]} >= vdc_reg))
                                    state_reg <= ST_DFIN;
                                else
                                    state_reg <= ST_DIV;
                            end
                            default: state_reg <= ST_ALU;
                        endcase
                    end
                end
                ST_MUL:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg[1:0] == 2'd3)
                        state_reg <= ST_MFIN;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd62)
                        state_reg <= ST_DFIN;
                end
                ST_MFIN, ST_ALU, ST_DFIN:
                begin
                    pc_reg    <= pc_reg + 6'd1;
                    state_reg <= ST_FETCH;
                end
                ST_DONE:
                begin
                    if (!result_stall)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (wr_en)
            begin
                case (uop_reg.dst)
                    DST_INTD: intd_reg <= wr_val;
                    DST_INTQ: intq_reg <= wr_val;
                    DST_RESD:
                    begin
                        rhd1_reg <= rhd0_reg;
                        rhd0_reg <= wr_val;
                    end
                    DST_RESQ:
                    begin
                        rhq1_reg <= rhq0_reg;
                        rhq0_reg <= wr_val;
                    end
                    DST_NOTCHD:
                    begin
                        nod1_reg <= nod0_reg;
                        nod0_reg <= wr_val;
                        nid1_reg <= nid0_reg;
                        nid0_reg <= sc_reg;
                    end
                    DST_NOTCHQ:
                    begin
                        noq1_reg <= noq0_reg;
                        noq0_reg <= wr_val;
                        niq1_reg <= niq0_reg;
                        niq0_reg <= sc_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            rd_reg  <= {{16{sample.ref_current_d[31]}}, sample.ref_current_d, 16'd0};
            rq_reg  <= {{16{sample.ref_current_q[31]}}, sample.ref_current_q, 16'd0};
            idm_reg <= {{16{sample.meas_current_d[31]}}, sample.meas_current_d, 16'd0};
            iqm_reg <= {{16{sample.meas_current_q[31]}}, sample.meas_current_q, 16'd0};
            vd_reg  <= {{16{sample.meas_voltage_d[31]}}, sample.meas_voltage_d, 16'd0};
            vq_reg  <= {{16{sample.meas_voltage_q[31]}}, sample.meas_voltage_q, 16'd0};
            w_reg   <= {{32{sample.grid_omega[31]}}, sample.grid_omega};
            vdc_reg <= sample.dc_link_voltage;
            cmd_reg <= sample.integ_command;
        end

        if ((state_reg == ST_FETCH) && (pc_reg != PROG_LEN) && cond_ok)
        begin
            uop_reg   <= uop;
            va_reg    <= fa;
            vb_reg    <= fb;
            ma_reg    <= fma;
            mb_reg    <= fmb;
            sign_reg  <= fa[63] ^ fb[63] ^ uop.neg;
            acc_reg   <= round_c;
            rem_reg   <= {13'd0, fma[63:46]};
            dq_reg    <= {fma[45:0], 17'd0};
            dzero_reg <= (vdc_reg == 31'd0);
            dovf_reg  <= ({13'd0, fma[63:46]} >= vdc_reg);
        end

        if (state_reg == ST_MUL)
            acc_reg <= acc_reg + pp_shift;

        if (state_reg == ST_DIV)
        begin
            rem_reg <= trial_ge ? (trial[30:0] - vdc_reg) : trial[30:0];
            dq_reg  <= {dq_reg[61:0], trial_ge};
        end

        if (wr_en)
        begin
            case (uop_reg.dst)
                DST_T0:   t0_reg   <= wr_val;
                DST_T1:   t1_reg   <= wr_val;
                DST_SC:   sc_reg   <= wr_val;
                DST_ED:   ed_reg   <= wr_val;
                DST_EQ:   eq_reg   <= wr_val;
                DST_WL:   wl_reg   <= wr_val;
                DST_OUTD: outd_reg <= wr_val;
                DST_OUTQ: outq_reg <= wr_val;
                default:  ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/dqpi_checker.sv @@
// Port-level checker for the dq current PI controller, bound to dq_current_pi_controller.
// Depends on dqpi_pkg and dq_current_pi_controller.
`default_nettype none

module dqpi_checker
    import dqpi_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    sample_valid,
    input wire logic    sample_stall,
    input wire sample_t sample,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    // The block holds a result only while it refuses new samples.
    a_stall_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> sample_stall)
        else $error("sample accepted while a result is pending");

    // An accepted sample does not have its result shown right after its transfer.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> !result_valid)
        else $error("result shown right after sample transfer");

    // A result does not stay valid after it transfers, so it is not repeated.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall) |=> !result_valid)
        else $error("result repeated after transfer");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

endmodule

bind dq_current_pi_controller dqpi_checker u_dqpi_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the dq current PI controller: a bit-accurate predictor
// drives a scoreboard of expected modulation results under random idling and stalls.
// Depends on dqpi_pkg and dq_current_pi_controller.
`default_nettype none

module tb_top;
    import dqpi_pkg::*;

    localparam int SW = 48;
    localparam int IDLE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic sample_valid;
    logic sample_stall;
    sample_t sample;
    logic result_valid;
    logic result_stall;
    result_t result;
    logic cfg_write_en;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    dq_current_pi_controller dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Controller copy: registers and state.
    logic [31:0] kp, ki, ind, ts;
    logic [1:0] rmode;
    longint kn, an, bn;
    longint integ_d, integ_q;
    longint res_d[2], res_q[2], nin_d[2], nin_q[2], nout_d[2], nout_q[2];

    result_t expected_q[$];
    int fail_count = 0;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int sent_count = 0;
    int checked_count = 0;
    int quiet_cycles = 0;

    function automatic longint sat_w(longint x, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return x > hi ? hi : (x < lo ? lo : x);
    endfunction

    function automatic longint sat_add(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        return sat_w(s > 65'sh0_7FFF_FFFF_FFFF_FFFF ? 64'sh7FFF_FFFF_FFFF_FFFF :
                     s < -65'sh0_8000_0000_0000_0000 ? 64'sh8000_0000_0000_0000 :
                     longint'(s), SW);
    endfunction

    function automatic longint sat_sub(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        return sat_w(s > 65'sh0_7FFF_FFFF_FFFF_FFFF ? 64'sh7FFF_FFFF_FFFF_FFFF :
                     s < -65'sh0_8000_0000_0000_0000 ? 64'sh8000_0000_0000_0000 :
                     longint'(s), SW);
    endfunction

    function automatic longint mul_round(longint a, longint b, int sh);
        logic [63:0] ua, ub, res;
        logic [128:0] p;
        logic neg;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        neg = (a < 0) != (b < 0);
        p = (129'(ua) * 129'(ub) + (129'(1) << (sh - 1))) >> sh;
        res = p > 129'h7FFF_FFFF_FFFF_FFFF ? 64'h7FFF_FFFF_FFFF_FFFF : p[63:0];
        return sat_w(neg ? -longint'(res) : longint'(res), SW);
    endfunction

    function automatic longint dc_scale(longint s, logic [30:0] v);
        logic [63:0] mag, q, res;
        if (v == 0)
            return s == 0 ? 0 : (s > 0 ? sat_w(64'sh7FFF_FFFF_FFFF_FFFF, SW)
                                       : sat_w(64'sh8000_0000_0000_0000, SW));
        mag = s < 0 ? -s : s;
        q = mag / v;
        if (q >= (64'd1 << 46)) res = 64'h7FFF_FFFF_FFFF_FFFF;
        else res = (q << 17) + (((mag % v) << 17) / v);
        return sat_w(s < 0 ? -longint'(res) : longint'(res), SW);
    endfunction

    function automatic longint resonant_step(longint x, ref longint h[2]);
        longint r;
        r = mul_round(-x, longint'(ts), 32);
        r = sat_sub(sat_add(r, mul_round(h[0], CWT2_Q28, 28)), h[1]);
        h[1] = h[0];
        h[0] = r;
        return r;
    endfunction

    function automatic longint notch_step(longint e, ref longint ein[2], ref longint xo[2]);
        longint inner, x;
        inner = sat_sub(mul_round(kn, ein[0], 28), mul_round(C707_Q28, xo[0], 28));
        x = sat_sub(mul_round(kn, e, 28), mul_round(an, inner, 28));
        x = sat_sub(sat_add(x, mul_round(kn, ein[1], 28)), mul_round(bn, xo[1], 28));
        ein[1] = ein[0];
        ein[0] = e;
        xo[1] = xo[0];
        xo[0] = x;
        return x;
    endfunction

    function automatic result_t predict_modulation(sample_t s);
        result_t r;
        longint rd, rq, idm, iqm, vd, vq, w, ed, eq, sd, sq, wl, xd, xq;
        longint rcd, rcq, rvd, rvq;
        rd = longint'(s.ref_current_d) * 65536;
        rq = longint'(s.ref_current_q) * 65536;
        idm = longint'(s.meas_current_d) * 65536;
        iqm = longint'(s.meas_current_q) * 65536;
        vd = longint'(s.meas_voltage_d) * 65536;
        vq = longint'(s.meas_voltage_q) * 65536;
        w = longint'(s.grid_omega);
        rcd = 0; rcq = 0; rvd = 0; rvq = 0;
        if (s.integ_command == CMD_CLEAR)
        begin
            integ_d = 0;
            integ_q = 0;
        end
        if (rmode == MODE_CURRENT)
        begin
            rcd = resonant_step(idm, res_d);
            rcq = resonant_step(iqm, res_q);
        end
        else if (rmode == MODE_VOLTAGE)
        begin
            rvd = resonant_step(vd, res_d);
            rvq = resonant_step(vq, res_q);
        end
        ed = sat_add(sat_sub(rd, idm), rvd);
        eq = sat_add(sat_sub(rq, iqm), rvq);
        wl = mul_round(w, longint'(ind), 16);
        sd = sat_add(mul_round(longint'(kp), ed, 16), mul_round(longint'(ki), integ_d, 16));
        sd = sat_add(sat_add(sat_sub(sd, mul_round(wl, iqm, 32)), vd), rcd);
        sq = sat_add(mul_round(longint'(kp), eq, 16), mul_round(longint'(ki), integ_q, 16));
        sq = sat_add(sat_add(sat_add(sq, mul_round(wl, idm, 32)), vq), rcq);
        xd = notch_step(dc_scale(sd, s.dc_link_voltage), nin_d, nout_d);
        xq = notch_step(dc_scale(sq, s.dc_link_voltage), nin_q, nout_q);
        if (s.integ_command == CMD_INTEGRATE)
        begin
            integ_d = sat_add(integ_d, mul_round(ed, longint'(ts), 32));
            integ_q = sat_add(integ_q, mul_round(eq, longint'(ts), 32));
        end
        r.modulation_d = 32'(sat_w(mul_round(xd, 1, 16), 32));
        r.modulation_q = 32'(sat_w(mul_round(xq, 1, 16), 32));
        r.dc_zero_flag = s.dc_link_voltage == 0;
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        result_stall = 0;
        forever
        begin
            @(negedge clk);
            result_stall <= $urandom_range(99) < stall_pct;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer");
                fail_count++;
            end
            else
            begin
                result_t e;
                e = expected_q.pop_front();
                checked_count++;
                if (result.modulation_d !== e.modulation_d)
                begin
                    $error("modulation_d expected %0d actual %0d", e.modulation_d,
                           result.modulation_d);
                    fail_count++;
                end
                if (result.modulation_q !== e.modulation_q)
                begin
                    $error("modulation_q expected %0d actual %0d", e.modulation_q,
                           result.modulation_q);
                    fail_count++;
                end
                if (result.dc_zero_flag !== e.dc_zero_flag)
                begin
                    $error("dc_zero_flag expected %0d actual %0d", e.dc_zero_flag,
                           result.dc_zero_flag);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_write_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write_en <= 0;
        case (idx)
            CFG_PROP_GAIN:     kp = val;
            CFG_INTEG_GAIN:    ki = val;
            CFG_INDUCTANCE:    ind = val;
            CFG_SAMPLE_PERIOD: ts = val;
            CFG_RESONANT_MODE: rmode = val[1:0];
            CFG_NOTCH_GAIN:    kn = longint'(signed'(val));
            CFG_NOTCH_A:       an = longint'(signed'(val));
            CFG_NOTCH_B:       bn = longint'(signed'(val));
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic drain;
        wait (expected_q.size() == 0);
        repeat (IDLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_sample(sample_t s);
        while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
        sample_valid <= 1;
        sample <= s;
        expected_q.push_back(predict_modulation(s));
        sent_count++;
        do @(posedge clk); while (sample_stall);
        @(negedge clk);
        sample_valid <= 0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 0;
            3: return $urandom();
            default: return 32'(signed'($urandom_range(20000)) - 10000) <<< $urandom_range(16);
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s.ref_current_d = pick32();
        s.ref_current_q = pick32();
        s.meas_current_d = pick32();
        s.meas_current_q = pick32();
        s.meas_voltage_d = pick32();
        s.meas_voltage_q = pick32();
        s.grid_omega = $urandom_range(9) == 0 ? pick32() : 32'(20587000 + $urandom_range(65536));
        case ($urandom_range(9))
            0: s.dc_link_voltage = 0;
            1: s.dc_link_voltage = 31'h7FFF_FFFF;
            2: s.dc_link_voltage = $urandom();
            default: s.dc_link_voltage = 31'($urandom_range(800 << 16, 1));
        endcase
        s.integ_command = $urandom_range(9) == 0 ? 2'($urandom_range(3))
                                                 : 2'($urandom_range(2, 1) - 1);
        return s;
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_sample(random_sample());
    endtask

    task automatic test_directed;
        sample_t s;
        s = '0;
        s.dc_link_voltage = 31'd400 << 16;
        s.integ_command = CMD_INTEGRATE;
        send_sample(s);
        s.ref_current_d = 32'h7FFF_FFFF;
        s.ref_current_q = 32'h8000_0000;
        s.meas_current_d = 32'h8000_0000;
        s.meas_current_q = 32'h7FFF_FFFF;
        send_sample(s);
        s.meas_voltage_d = 32'h7FFF_FFFF;
        s.meas_voltage_q = 32'h8000_0000;
        s.grid_omega = 32'h8000_0000;
        s.integ_command = 2'd2;
        send_sample(s);
        s.integ_command = 2'd3;
        s.grid_omega = 32'h7FFF_FFFF;
        send_sample(s);
        s.dc_link_voltage = 0;
        send_sample(s);
        s.dc_link_voltage = 31'h7FFF_FFFF;
        s.integ_command = CMD_CLEAR;
        send_sample(s);
        s = '0;
        send_sample(s);
        s.ref_current_d = 100 << 16;
        s.ref_current_q = -(50 << 16);
        s.dc_link_voltage = 1;
        s.integ_command = CMD_INTEGRATE;
        send_sample(s);
        s.ref_current_d = -(100 << 16);
        s.dc_link_voltage = 0;
        send_sample(s);
        repeat (4) send_sample(random_sample());
    endtask

    task automatic test_config_sweep;
        logic [31:0] v;
        for (int k = 0; k < 6; k++)
        begin
            drain();
            write_reg(CFG_PROP_GAIN, k == 0 ? 32'hFFFF_FFFF : $urandom_range(1 << 20));
            write_reg(CFG_INTEG_GAIN, k == 1 ? 32'hFFFF_FFFF : $urandom_range(1 << 22));
            write_reg(CFG_INDUCTANCE, k == 2 ? 32'hFFFF_FFFF : $urandom());
            write_reg(CFG_SAMPLE_PERIOD, k == 3 ? 32'hFFFF_FFFF : $urandom_range(1 << 20));
            write_reg(CFG_RESONANT_MODE, 32'(k % 4));
            v = k == 4 ? 32'h8000_0000 : (k == 5 ? 32'h7FFF_FFFF : NOTCH_GAIN_RST);
            write_reg(CFG_NOTCH_GAIN, v);
            write_reg(CFG_NOTCH_A, k == 4 ? 32'h7FFF_FFFF : NOTCH_A_RST);
            write_reg(CFG_NOTCH_B, k == 5 ? 32'h8000_0000 : NOTCH_B_RST);
            random_phase(20);
        end
        drain();
        write_reg(CFG_PROP_GAIN, 0);
        write_reg(CFG_INTEG_GAIN, 0);
        write_reg(CFG_INDUCTANCE, 0);
        write_reg(CFG_SAMPLE_PERIOD, 0);
        write_reg(CFG_RESONANT_MODE, 0);
        random_phase(10);
    endtask

    task automatic test_random_traffic;
        int pcts[4][2] = '{'{0, 0}, '{83, 0}, '{0, 83}, '{30, 30}};
        for (int p = 0; p < 4; p++)
        begin
            drain();
            sender_idle_pct = pcts[p][0];
            stall_pct = pcts[p][1];
            write_reg(CFG_PROP_GAIN, $urandom_range(3 << 16));
            write_reg(CFG_INTEG_GAIN, $urandom_range(200 << 16));
            write_reg(CFG_INDUCTANCE, $urandom_range(32'h0100_0000));
            write_reg(CFG_SAMPLE_PERIOD, $urandom_range(32'h0010_0000));
            write_reg(CFG_RESONANT_MODE, $urandom_range(3));
            random_phase(150);
            drain();
            write_reg(CFG_RESONANT_MODE, $urandom_range(2, 1));
            random_phase(150);
        end
        sender_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        rst_n = 0;
        sample_valid = 0;
        sample = '0;
        cfg_write_en = 0;
        cfg_index = CFG_PROP_GAIN;
        cfg_data = 0;
        kp = 0; ki = 0; ind = 0; ts = 0; rmode = 0;
        kn = longint'(signed'(NOTCH_GAIN_RST));
        an = longint'(signed'(NOTCH_A_RST));
        bn = longint'(signed'(NOTCH_B_RST));
        integ_d = 0; integ_q = 0;
        res_d = '{0, 0}; res_q = '{0, 0};
        nin_d = '{0, 0}; nin_q = '{0, 0};
        nout_d = '{0, 0}; nout_q = '{0, 0};
        repeat (4) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_directed();
        test_config_sweep();
        test_random_traffic();
        drain();
        $display("Sent %0d samples, checked %0d results across register sweeps,",
                 sent_count, checked_count);
        $display("resonant modes, integrator commands and four idle/stall mixes.");
        if (fail_count == 0 && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

`default_nettype wire
